FILE: rtl/mbps_pkg.sv
// Package for the masked byte pattern search: sizes, register map and types.
`default_nettype none
package mbps_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int ADDR_BITS   = 32;

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W = 5;

  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

  typedef logic [7:0] byte_t;

  // Register indexes, byte address = 8 * index
  typedef enum logic [2:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LEN    = 3'd3,
    REG_BASE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care;
    logic [4:0]  len;
    logic [31:0] base;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search: cell chain, counters, output stage.
`default_nettype none
// Usage
//   Input channel (in_valid/in_ready): one byte of the scanned region per item,
//   in address order, with in_last_byte marking the region's final byte.
//   Result channel (out_valid/out_ready): at most one item per region. found=1
//   with the start address of the first match, or found=0 / address 0 when the
//   region ends without a match. After a match, bytes are dropped up to and
//   including the last one.
//   Config: APB, 64-bit registers at 8*index (pattern low, pattern high, care
//   mask, length, base address). Write only while the scanner is idle.
// Timing
//   One item per cycle sustained unless stalled. The window is a chain of 16
//   cells that shift on each taken byte; all cells compare in parallel, so the
//   result is registered at the accept edge and shows in the next cycle.
//   in_ready is high whenever the output register is empty or being drained.
// Reset / stall
//   Synchronous active-low reset clears the window, byte count, match flag and
//   output valid flag and loads the register defaults. No clearing pass is needed.
//   A stalled receiver holds the result; input then stops once the register
//   holds an untaken result.
module masked_byte_pattern_search
  import mbps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic      [31:0] out_match_address,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------- control
  logic        accept, active, clear, match, emit;
  logic [31:0] seen_r, seen_nxt, seen_inc;
  logic        done_r, done_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        found_r, found_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [LEN_W-1:0] n_used;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign active   = accept && !done_r;        // after a match, bytes are dropped
  assign clear    = accept && in_last_byte;   // region end resets the window

  // length 0 acts as 1, above the window depth acts as the depth
  always_comb begin
    if (cfg.len == '0)
      n_used = LEN_W'(1);
    else if (cfg.len > LEN_W'(PATTERN_MAX))
      n_used = LEN_W'(PATTERN_MAX);
    else
      n_used = cfg.len;
  end

  // ---------------------------------------------------------------- cell chain
  byte_t pat [16];
  byte_t cell_byte [PATTERN_MAX];
  byte_t cell_in   [PATTERN_MAX];
  logic  [PATTERN_MAX-1:0] cell_valid, valid_in, cell_hit;

  for (genvar i = 0; i < 8; i++) begin : g_pat
    assign pat[i]     = cfg.pat_lo[8*i +: 8];
    assign pat[i + 8] = cfg.pat_hi[8*i +: 8];
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [IDX_W-1:0] pidx;
    logic             use_k;

    // newest byte sits in cell 0; cell k lines up with pattern byte n-1-k
    assign pidx  = IDX_W'(n_used - LEN_W'(k + 1));
    assign use_k = n_used > LEN_W'(k);

    if (k == 0) begin : g_head
      assign cell_in[k]  = in_data_byte;
      assign valid_in[k] = 1'b1;
    end else begin : g_body
      assign cell_in[k]  = cell_byte[k-1];
      assign valid_in[k] = cell_valid[k-1];
    end

    mbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (active),
      .clear     (clear),
      .byte_in   (cell_in[k]),
      .valid_in  (valid_in[k]),
      .pat_byte  (pat[pidx]),
      .care_bit  (cfg.care[pidx]),
      .in_use    (use_k),
      .byte_out  (cell_byte[k]),
      .valid_out (cell_valid[k]),
      .hit       (cell_hit[k])
    );
  end

  // a full window of n region bytes is needed before a match counts
  assign match = (&cell_hit) && valid_in[IDX_W'(n_used - LEN_W'(1))];
  assign emit  = active && (match || in_last_byte);

  // saturating byte count
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + 32'd1;

  always_comb begin
    seen_nxt = seen_r;
    done_nxt = done_r;
    if (clear) begin
      seen_nxt = '0;
      done_nxt = 1'b0;
    end else if (active) begin
      seen_nxt = seen_inc;
      if (match)
        done_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------- output stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    addr_nxt      = addr_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      found_nxt     = match;
      addr_nxt      = match ? ((cfg.base + seen_inc - 32'(n_used)) & ADDR_MASK) : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    addr_r  <= addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = addr_r;

  // ---------------------------------------------------------------- checks
  a_region_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> !done_r && (seen_r == '0) && (cell_valid == '0))
    else $error("region state not cleared after last item");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !done_r && in_last_byte |=> out_valid_r)
    else $error("region end without a result item");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_r && !in_last_byte |=> done_r && $stable(seen_r))
    else $error("state moved while dropping bytes after a match");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> addr_r == '0)
    else $error("not-found result carries an address");

endmodule
`default_nettype wire

FILE: rtl/mbps_cfg.sv
// APB register file of the masked byte pattern search.
`default_nettype none
module mbps_cfg
  import mbps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_lo <= '0;
      cfg_r.pat_hi <= '0;
      cfg_r.care   <= 16'hFFFF;
      cfg_r.len    <= 5'd1;
      cfg_r.base   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAT_LO: cfg_r.pat_lo <= pwdata;
        REG_PAT_HI: cfg_r.pat_hi <= pwdata;
        REG_CARE:   cfg_r.care   <= pwdata[15:0];
        REG_LEN:    cfg_r.len    <= pwdata[4:0];
        REG_BASE:   cfg_r.base   <= pwdata[31:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAT_LO: prdata = cfg_r.pat_lo;
      REG_PAT_HI: prdata = cfg_r.pat_hi;
      REG_CARE:   prdata = {48'd0, cfg_r.care};
      REG_LEN:    prdata = {59'd0, cfg_r.len};
      REG_BASE:   prdata = {32'd0, cfg_r.base};
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mbps_cell.sv
// One window cell: holds a byte and its filled flag, compares the incoming byte.
`default_nettype none
module mbps_cell
  import mbps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  shift_en,
  input  wire logic  clear,
  input  wire byte_t byte_in,
  input  wire logic  valid_in,
  input  wire byte_t pat_byte,
  input  wire logic  care_bit,
  input  wire logic  in_use,
  output byte_t      byte_out,
  output logic       valid_out,
  output logic       hit
);

  byte_t byte_r;
  logic  valid_r;

  // compare against the byte this cell takes on the shift
  assign hit       = !in_use || !care_bit || (byte_in == pat_byte);
  assign byte_out  = byte_r;
  assign valid_out = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r  <= '0;
      valid_r <= 1'b0;
    end else if (clear) begin
      byte_r  <= '0;
      valid_r <= 1'b0;
    end else if (shift_en) begin
      byte_r  <= byte_in;
      valid_r <= valid_in;
    end
  end

endmodule
`default_nettype wire
